// ===== sv/dllo_pkg.sv =====
package dllo_pkg;

    // default sizes of the slot pool and of one stored item
    localparam int SLOTS_DEF     = 64;
    localparam int ITEM_BITS_DEF = 32;

    // field widths on the stream ports
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int HANDLE_W  = 6;
    localparam int RSLOT_W   = 6;
    localparam int FITEM_W   = 32;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // free slot search works on groups of this many slots
    localparam int GRP_W     = 8;
    localparam int GRP_BIT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_MOVE   = 3'd2,
        CMD_FRONT  = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_BAD   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIND_GRP,
        ST_FIND_BIT,
        ST_UNLINK,
        ST_LINK_A,
        ST_LINK_B,
        ST_FRONT_RD,
        ST_REPORT
    } ctl_state_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_CLEAR,
        DP_FIND_GRP,
        DP_FIND_BIT,
        DP_UNLINK,
        DP_LINK_A,
        DP_LINK_B,
        DP_FRONT
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    res_init;
        status_t status;
        dp_op_t  op;
        logic    add;
        logic    remove;
        logic    out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic bad_handle;
        logic is_front;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/dllo_ctrl.sv =====
module dllo_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dllo_pkg::dp_stat_t stat,
    output dllo_pkg::dp_cmd_t  cmd
);
    import dllo_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.status   = STATUS_OK;
        cmd.op       = DP_NOP;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.res_init = 1'b1;
                state_next   = ST_REPORT;
                case (stat.cmd)
                    CMD_ADD: begin
                        if (stat.full) begin
                            cmd.status = STATUS_FULL;
                        end else begin
                            state_next = ST_FIND_GRP;
                        end
                    end
                    CMD_REMOVE: begin
                        if (stat.bad_handle) begin
                            cmd.status = STATUS_BAD;
                        end else begin
                            state_next = ST_UNLINK;
                        end
                    end
                    CMD_MOVE: begin
                        if (stat.bad_handle) begin
                            cmd.status = STATUS_BAD;
                        end else if (!stat.is_front) begin
                            state_next = ST_UNLINK;
                        end
                    end
                    CMD_FRONT: begin
                        if (stat.empty) begin
                            cmd.status = STATUS_EMPTY;
                        end else begin
                            state_next = ST_FRONT_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        cmd.op = DP_CLEAR;
                    end
                    default: begin
                        state_next = ST_REPORT;
                    end
                endcase
            end
            ST_FIND_GRP: begin
                cmd.op     = DP_FIND_GRP;
                state_next = ST_FIND_BIT;
            end
            ST_FIND_BIT: begin
                cmd.op     = DP_FIND_BIT;
                state_next = ST_LINK_A;
            end
            ST_UNLINK: begin
                cmd.op     = DP_UNLINK;
                cmd.remove = (stat.cmd == CMD_REMOVE);
                state_next = (stat.cmd == CMD_REMOVE) ? ST_REPORT : ST_LINK_A;
            end
            ST_LINK_A: begin
                cmd.op     = DP_LINK_A;
                cmd.add    = (stat.cmd == CMD_ADD);
                state_next = ST_LINK_B;
            end
            ST_LINK_B: begin
                cmd.op     = DP_LINK_B;
                cmd.add    = (stat.cmd == CMD_ADD);
                state_next = ST_REPORT;
            end
            ST_FRONT_RD: begin
                cmd.op     = DP_FRONT;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/dllo_dp.sv =====
module dllo_dp #(
    parameter int SLOTS     = dllo_pkg::SLOTS_DEF,
    parameter int ITEM_BITS = dllo_pkg::ITEM_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [dllo_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dllo_pkg::M_TDATA_W-1:0]   m_tdata,
    input  dllo_pkg::dp_cmd_t                cmd,
    output dllo_pkg::dp_stat_t               stat
);
    import dllo_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int LNK_W = $clog2(SLOTS + 1);
    localparam int NG    = (SLOTS + GRP_W - 1) / GRP_W;
    localparam int GI_W  = (NG > 1) ? $clog2(NG) : 1;
    localparam int PAD_W = NG * GRP_W;
    localparam logic [LNK_W-1:0] NONE = LNK_W'(SLOTS);
    localparam int VAL_LO = CMD_W;
    localparam int HDL_LO = CMD_W + VALUE_W;

    // captured command
    cmd_t                 cmd_reg;
    logic [ITEM_BITS-1:0] item_reg;
    logic [HANDLE_W-1:0]  handle_reg;
    logic [IDX_W-1:0]     tgt_reg;

    // list state
    logic [SLOTS-1:0]     used_reg, used_next;
    logic [LNK_W-1:0]     front_reg, front_next;
    logic [LNK_W-1:0]     count_reg, count_next;

    // slot pool memories
    logic [ITEM_BITS-1:0] item_mem [SLOTS];
    logic [LNK_W-1:0]     next_mem [SLOTS];
    logic [LNK_W-1:0]     prev_mem [SLOTS];
    logic [LNK_W-1:0]     prev_rd_reg;
    logic [LNK_W-1:0]     next_rd_reg;
    logic [ITEM_BITS-1:0] item_rd_reg;

    // free slot search
    logic [PAD_W-1:0]     free_pad;
    logic [NG-1:0]        grp_free;
    logic [NG-1:0]        grp_free_reg;
    logic [GI_W-1:0]      grp_low;
    logic [GI_W-1:0]      grp_idx_reg;
    logic [GRP_W-1:0]     grp_bits;
    logic [GRP_BIT_W-1:0] bit_low;
    logic [IDX_W-1:0]     found_slot;

    // result staging and output register
    logic [IDX_W-1:0]     res_slot_reg;
    logic [ITEM_BITS-1:0] res_item_reg;
    status_t              res_status_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // memory write ports
    logic                 item_we;
    logic                 next_we;
    logic [IDX_W-1:0]     next_wa;
    logic [LNK_W-1:0]     next_wd;
    logic                 prev_we;
    logic [IDX_W-1:0]     prev_wa;
    logic [LNK_W-1:0]     prev_wd;

    logic [IDX_W-1:0]     hidx;
    logic [IDX_W-1:0]     front_idx;
    logic                 p_none;
    logic                 n_none;

    assign hidx      = IDX_W'(handle_reg);
    assign front_idx = front_reg[IDX_W-1:0];
    assign p_none    = (prev_rd_reg == NONE);
    assign n_none    = (next_rd_reg == NONE);

    // status toward the controller
    assign stat.cmd        = cmd_reg;
    assign stat.full       = (count_reg == NONE);
    assign stat.empty      = (count_reg == '0);
    assign stat.bad_handle = (32'(handle_reg) >= 32'(SLOTS)) || !used_reg[hidx];
    assign stat.is_front   = (front_reg == LNK_W'(handle_reg));
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // free bits per group, padding slots count as taken
    always_comb begin
        free_pad              = '0;
        free_pad[SLOTS-1:0]   = ~used_reg;
        for (int g = 0; g < NG; g++) begin
            grp_free[g] = |free_pad[g*GRP_W +: GRP_W];
        end
    end

    // lowest group with a free slot
    always_comb begin
        grp_low = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (grp_free_reg[g]) begin
                grp_low = GI_W'(g);
            end
        end
    end

    // lowest free slot inside the chosen group
    always_comb begin
        grp_bits = free_pad[grp_idx_reg*GRP_W +: GRP_W];
        bit_low  = '0;
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                bit_low = GRP_BIT_W'(b);
            end
        end
        found_slot = IDX_W'({grp_idx_reg, bit_low});
    end

    // list state update and memory write ports
    always_comb begin
        used_next  = used_reg;
        front_next = front_reg;
        count_next = count_reg;
        item_we    = 1'b0;
        next_we    = 1'b0;
        next_wa    = tgt_reg;
        next_wd    = front_reg;
        prev_we    = 1'b0;
        prev_wa    = tgt_reg;
        prev_wd    = NONE;
        case (cmd.op)
            DP_CLEAR: begin
                used_next  = '0;
                front_next = NONE;
                count_next = '0;
            end
            DP_UNLINK: begin
                // bridge the neighbors over the slot
                next_we = !p_none;
                next_wa = prev_rd_reg[IDX_W-1:0];
                next_wd = next_rd_reg;
                prev_we = !n_none;
                prev_wa = next_rd_reg[IDX_W-1:0];
                prev_wd = prev_rd_reg;
                if (p_none) begin
                    front_next = next_rd_reg;
                end
                if (cmd.remove) begin
                    used_next[tgt_reg] = 1'b0;
                    count_next         = count_reg - LNK_W'(1);
                end
            end
            DP_LINK_A: begin
                // slot points at the old front
                item_we = cmd.add;
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            DP_LINK_B: begin
                // old front points back at the slot
                prev_we    = (front_reg != NONE);
                prev_wa    = front_idx;
                prev_wd    = LNK_W'(tgt_reg);
                front_next = LNK_W'(tgt_reg);
                if (cmd.add) begin
                    used_next[tgt_reg] = 1'b1;
                    count_next         = count_reg + LNK_W'(1);
                end
            end
            default: begin
                used_next = used_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            front_reg   <= NONE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg  <= used_next;
            front_reg <= front_next;
            count_reg <= count_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        grp_free_reg <= grp_free;
        if (cmd.capture) begin
            cmd_reg    <= cmd_t'(s_tdata[CMD_W-1:0]);
            item_reg   <= ITEM_BITS'(s_tdata[VAL_LO +: VALUE_W]);
            handle_reg <= s_tdata[HDL_LO +: HANDLE_W];
            tgt_reg    <= IDX_W'(s_tdata[HDL_LO +: HANDLE_W]);
        end else if (cmd.op == DP_FIND_BIT) begin
            tgt_reg <= found_slot;
        end
        if (cmd.op == DP_FIND_GRP) begin
            grp_idx_reg <= grp_low;
        end
        if (cmd.res_init) begin
            res_status_reg <= cmd.status;
            res_slot_reg   <= '0;
            res_item_reg   <= '0;
        end else if (cmd.op == DP_LINK_B && cmd.add) begin
            res_slot_reg <= tgt_reg;
        end else if (cmd.op == DP_FRONT) begin
            res_slot_reg <= front_idx;
            res_item_reg <= item_rd_reg;
        end
        if (cmd.out_load) begin
            m_data_reg <= {1'b0, res_status_reg, COUNT_W'(count_reg),
                           FITEM_W'(res_item_reg), RSLOT_W'(res_slot_reg)};
        end
    end

    // pool memories, registered reads
    always_ff @(posedge aclk) begin
        if (item_we) begin
            item_mem[tgt_reg] <= item_reg;
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_rd_reg <= prev_mem[hidx];
        next_rd_reg <= next_mem[hidx];
        item_rd_reg <= item_mem[front_idx];
    end

endmodule

// ===== sv/doubly_linked_order_list.sv =====
// LRU-ordered doubly linked list over a pool of SLOTS slots. Each command
// transfer on the s_ side yields exactly one result transfer on the m_ side,
// carrying the entry count after the command. Add takes the lowest free slot
// and pushes the item at the front; remove unlinks and frees a slot; move to
// front relinks a slot at the head; read front returns the head slot and item;
// clear empties the list. Commands are handled one at a time: after decode,
// add runs the grouped free-slot search (group, then bit) and relinks in the
// link A and link B steps, move to front unlinks and relinks unless the slot
// is already at the head, remove unlinks, read front reads the head, and
// every command ends in the report state, which loads the result register;
// the next command is taken only after that load. The relinking is split by
// the single write port of each link memory, which allows one link update
// per memory per cycle. A finished result waits in the output register while
// the next command is accepted. Item and link memories need no clearing after
// reset; the slot used map is cleared at once.
module doubly_linked_order_list #(
    parameter int SLOTS     = dllo_pkg::SLOTS_DEF,
    parameter int ITEM_BITS = dllo_pkg::ITEM_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command[2:0], item_value[34:3], slot_handle[40:35], zero fill[47:41]
    input  logic [dllo_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_slot[5:0], front_item[37:6], entry_count[44:38], status[46:45],
    // zero fill[47]
    output logic [dllo_pkg::M_TDATA_W-1:0] m_tdata
);
    import dllo_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer
    dllo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // list state, pool memories and result register
    dllo_dp #(
        .SLOTS     (SLOTS),
        .ITEM_BITS (ITEM_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

endmodule

// ===== sv/dllo_checker.sv =====
module dllo_checker #(
    parameter int SLOTS = dllo_pkg::SLOTS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dllo_pkg::M_TDATA_W-1:0] m_tdata
);
    import dllo_pkg::*;

    localparam int CNT_LO  = RSLOT_W + FITEM_W;
    localparam int STAT_LO = CNT_LO + COUNT_W;

    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;

    assign res_status = m_tdata[STAT_LO +: STATUS_W];
    assign res_count  = m_tdata[CNT_LO +: COUNT_W];

    // a stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in flight");

    // pool full only with every slot in the list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_status == STATUS_FULL) |-> res_count == COUNT_W'(SLOTS))
        else $error("pool full reported with free slots");

    // list empty only with no entries
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_status == STATUS_EMPTY) |-> res_count == '0)
        else $error("list empty reported with entries");

endmodule

bind doubly_linked_order_list dllo_checker #(.SLOTS(SLOTS)) u_dllo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
